### sv/cpgn_pkg.sv
package cpgn_pkg;

	localparam int CHUNK_DEPTH_DEF = 1024;
	localparam int SAMPLE_BITS_DEF = 24;

	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;
	localparam int REG_LSB = 2;

	localparam int LEN_BITS   = 11;
	localparam int LEVEL_BITS = 24;
	localparam logic [LEN_BITS-1:0]   LEN_RESET   = 11'd882;
	localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = 24'd8388608;

	localparam int GAIN_BITS = 23;
	localparam int GAIN_FRAC = 16;
	localparam logic [GAIN_BITS-1:0] GAIN_ONE   = 23'd65536;
	localparam logic [GAIN_BITS-1:0] GAIN_LIMIT = 23'd6553600;
	localparam logic [GAIN_BITS-1:0] GAIN_STEP  = 23'd68813;
	localparam logic [GAIN_BITS-1:0] GAIN_MAX   = 23'd8388607;
	localparam int unsigned GAIN_HALF = 32'd32768;

	localparam int DIV_BITS = LEVEL_BITS + GAIN_FRAC;
	localparam int STEP_W   = 6;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_DRAIN  = 1'b1;

	typedef enum logic {
		REG_CHUNK_LENGTH = 1'b0,
		REG_MAX_LEVEL    = 1'b1
	} reg_idx_t;

	typedef enum logic {
		ALU_MUL = 1'b0,
		ALU_DIV = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic              start;
		alu_op_t           op;
		logic [STEP_W-1:0] steps;
	} alu_ctl_t;

	typedef struct packed {
		logic done;
		logic quo_wide;
	} alu_sts_t;

endpackage

### sv/cpgn_if.sv
interface cpgn_item_if #(
	parameter int SAMPLE_BITS = cpgn_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic                          cmd;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output cmd, output sample, input ready);
	modport sink (input valid, input cmd, input sample, output ready);
endinterface

interface cpgn_result_if #(
	parameter int SAMPLE_BITS = cpgn_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] scaled_sample;
	logic                          drain_done;

	modport source (output valid, output scaled_sample, output drain_done, input ready);
	modport sink (input valid, input scaled_sample, input drain_done, output ready);
endinterface

### sv/cpgn_regs.sv
module cpgn_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [cpgn_pkg::ADDR_W-1:0]         paddr,
	input  logic [cpgn_pkg::DATA_W-1:0]         pwdata,
	output logic [cpgn_pkg::DATA_W-1:0]         prdata,
	output logic                                pready,
	output logic [cpgn_pkg::LEN_BITS-1:0]       chunk_length,
	output logic [cpgn_pkg::LEVEL_BITS-1:0]     max_level
);

	logic [cpgn_pkg::LEN_BITS-1:0]   len_q;
	logic [cpgn_pkg::LEVEL_BITS-1:0] level_q;
	cpgn_pkg::reg_idx_t              sel;
	logic                            wr;

	assign sel    = cpgn_pkg::reg_idx_t'(paddr[cpgn_pkg::REG_LSB]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= cpgn_pkg::LEN_RESET;
			level_q <= cpgn_pkg::LEVEL_RESET;
		end else if (wr) begin
			unique case (sel)
				cpgn_pkg::REG_CHUNK_LENGTH: len_q   <= pwdata[cpgn_pkg::LEN_BITS-1:0];
				cpgn_pkg::REG_MAX_LEVEL:    level_q <= pwdata[cpgn_pkg::LEVEL_BITS-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			cpgn_pkg::REG_CHUNK_LENGTH: prdata = cpgn_pkg::DATA_W'(len_q);
			cpgn_pkg::REG_MAX_LEVEL:    prdata = cpgn_pkg::DATA_W'(level_q);
		endcase
	end

	assign chunk_length = len_q;
	assign max_level    = level_q;

endmodule

### sv/cpgn_store.sv
module cpgn_store #(
	parameter int DEPTH = cpgn_pkg::CHUNK_DEPTH_DEF,
	parameter int WIDTH = cpgn_pkg::SAMPLE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/cpgn_alu.sv
module cpgn_alu #(
	parameter int MW  = cpgn_pkg::SAMPLE_BITS_DEF + 1,
	parameter int DSW = cpgn_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  cpgn_pkg::alu_ctl_t                          ctl,
	input  logic signed [MW-1:0]                        a,
	input  logic [cpgn_pkg::GAIN_BITS-1:0]              b,
	input  logic [cpgn_pkg::DIV_BITS-1:0]               dvd,
	input  logic [DSW-1:0]                              dsr,
	output logic signed [MW+cpgn_pkg::GAIN_BITS:0]      prod,
	output logic [cpgn_pkg::DIV_BITS-1:0]               quo,
	output logic [DSW-1:0]                              rem,
	output cpgn_pkg::alu_sts_t                          sts
);

	localparam int DVW = cpgn_pkg::DIV_BITS;
	localparam int GB  = cpgn_pkg::GAIN_BITS;

	logic signed [GB:0]              b_s;
	logic [cpgn_pkg::STEP_W-1:0]     cnt_q;
	logic                            busy_q;
	logic                            done_q;
	logic [DVW-1:0]                  dvd_q;
	logic [DVW-1:0]                  quo_q;
	logic [DSW-1:0]                  dsr_q;
	logic [DSW-1:0]                  rem_q;
	logic [DSW:0]                    cand;
	logic                            fits;
	logic                            go_mul;
	logic                            go_div;

	assign b_s    = $signed({1'b0, b});
	assign go_mul = ctl.start && (ctl.op == cpgn_pkg::ALU_MUL);
	assign go_div = ctl.start && (ctl.op == cpgn_pkg::ALU_DIV);
	assign cand   = {rem_q, dvd_q[DVW-1]};
	assign fits   = cand >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go_div) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == cpgn_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring divide, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (go_mul) begin
			prod <= a * b_s;
		end
		if (go_div) begin
			dvd_q <= dvd;
			dsr_q <= dsr;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVW-2:0], 1'b0};
			quo_q <= {quo_q[DVW-2:0], fits};
			rem_q <= fits ? DSW'(cand - {1'b0, dsr_q}) : DSW'(cand);
		end
	end

	assign quo          = quo_q;
	assign rem          = rem_q;
	assign sts.done     = done_q;
	assign sts.quo_wide = |quo_q[DVW-1:GB];

endmodule

### sv/chunk_peak_gain_normalizer_core.sv
// Chunked peak gain control. Samples are stored per chunk of chunk_length entries while the
// chunk's absolute peak is tracked; each sample input returns the sample one chunk earlier,
// scaled by that chunk's gain (Q7.16) and saturated. An ordinary sample passes store read,
// shared multiply and output before the next transfer. The sample that closes a chunk then
// runs the gain update (ST_GSTEP, ST_GSCALE, ST_GCHK, ST_GCMP, ST_GFIN), and waits in ST_GDIV
// when the gain has to be cut, as the 40-bit quotient comes from the shared restoring divider
// at one bit a cycle. A drain step reads, multiplies and outputs; while a full chunk is held
// it first waits in ST_DMOD, as the read position modulo the chunk length is worked out on the
// same divider. Any step may also wait while the output register is still occupied. max_level
// is linear; dB conversion is left to software.
module chunk_peak_gain_normalizer_core #(
	parameter int CHUNK_DEPTH = cpgn_pkg::CHUNK_DEPTH_DEF,
	parameter int SAMPLE_BITS = cpgn_pkg::SAMPLE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cpgn_pkg::ADDR_W-1:0] paddr,
	input  logic [cpgn_pkg::DATA_W-1:0] pwdata,
	output logic [cpgn_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	cpgn_item_if.sink                   item,
	cpgn_result_if.source               result
);

	localparam int SB   = SAMPLE_BITS;
	localparam int GB   = cpgn_pkg::GAIN_BITS;
	localparam int LVB  = cpgn_pkg::LEVEL_BITS;
	localparam int FR   = cpgn_pkg::GAIN_FRAC;
	localparam int DVW  = cpgn_pkg::DIV_BITS;
	localparam int IW   = $clog2(CHUNK_DEPTH);
	localparam int LW   = $clog2(CHUNK_DEPTH + 1);
	localparam int CMPW = (LW > cpgn_pkg::LEN_BITS) ? LW : cpgn_pkg::LEN_BITS;
	localparam int MW   = ((SB > LVB) ? SB : LVB) + 1;
	localparam int PW   = MW + GB + 1;
	localparam int DSW  = (SB > LW) ? SB : LW;
	localparam int PAD  = DVW - LW - 1;
	localparam logic [SB-1:0] PEAK_FLOOR = SB'(((64'd1 << SB) + 64'd50) / 64'd100);
	localparam logic signed [PW-1:0] Y_HI = {{(PW-SB+1){1'b0}}, {(SB-1){1'b1}}};
	localparam logic signed [PW-1:0] Y_LO = {{(PW-SB+1){1'b1}}, {(SB-1){1'b0}}};

	typedef enum logic [11:0] {
		ST_IDLE   = 12'h001,
		ST_SMUL   = 12'h002,
		ST_SEMIT  = 12'h004,
		ST_GSTEP  = 12'h008,
		ST_GSCALE = 12'h010,
		ST_GCHK   = 12'h020,
		ST_GCMP   = 12'h040,
		ST_GDIV   = 12'h080,
		ST_GFIN   = 12'h100,
		ST_DMOD   = 12'h200,
		ST_DMUL   = 12'h400,
		ST_DEMIT  = 12'h800
	} state_t;

	state_t                  state_q;
	logic [IW-1:0]           fill_q;
	logic                    held_q;
	logic [LW-1:0]           drain_q;
	logic [SB-1:0]           peak_q;
	logic [GB-1:0]           gain_q;
	logic signed [SB-1:0]    sample_q;
	logic                    out_valid_q;
	logic [SB-1:0]           out_sample_q;
	logic                    out_done_q;

	logic [cpgn_pkg::LEN_BITS-1:0] chunk_length;
	logic [LVB-1:0]                max_level;

	cpgn_pkg::alu_ctl_t      alu_ctl;
	cpgn_pkg::alu_sts_t      alu_sts;
	logic signed [MW-1:0]    alu_a;
	logic [GB-1:0]           alu_b;
	logic [DVW-1:0]          alu_dvd;
	logic [DSW-1:0]          alu_dsr;
	logic signed [PW-1:0]    prod;
	logic [DVW-1:0]          quo;
	logic [DSW-1:0]          rem;

	logic                    rd_en;
	logic [IW-1:0]           rd_addr;
	logic [SB-1:0]           rd_data;
	logic                    wr_en;

	logic                    accept;
	logic [LW-1:0]           len_c;
	logic [LW-1:0]           total_c;
	logic [LW:0]             sum_c;
	logic [SB-1:0]           mag_c;
	logic [SB-1:0]           div_floor_c;
	logic signed [PW-1:0]    rnd_c;
	logic signed [PW-1:0]    y_c;
	logic [SB-1:0]           sat_c;
	logic                    last_fill_c;
	logic                    last_drain_c;
	logic                    out_free_c;
	logic                    over_c;
	logic                    grow_c;
	logic                    load_c;

	cpgn_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.chunk_length (chunk_length),
		.max_level    (max_level)
	);

	cpgn_store #(
		.DEPTH (CHUNK_DEPTH),
		.WIDTH (SB)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (fill_q),
		.wdata (sample_q),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	cpgn_alu #(
		.MW  (MW),
		.DSW (DSW)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (alu_ctl),
		.a      (alu_a),
		.b      (alu_b),
		.dvd    (alu_dvd),
		.dsr    (alu_dsr),
		.prod   (prod),
		.quo    (quo),
		.rem    (rem),
		.sts    (alu_sts)
	);

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;

	always_comb begin
		if (chunk_length == '0) begin
			len_c = LW'(1);
		end else if (CMPW'(chunk_length) > CMPW'(CHUNK_DEPTH)) begin
			len_c = LW'(CHUNK_DEPTH);
		end else begin
			len_c = LW'(chunk_length);
		end
	end

	assign total_c      = held_q ? len_c : LW'(fill_q);
	assign sum_c        = (LW+1)'(fill_q) + (LW+1)'(drain_q);
	assign last_fill_c  = ((LW+1)'(fill_q) + 1'b1) >= (LW+1)'(len_c);
	assign last_drain_c = ((LW+1)'(drain_q) + 1'b1) >= (LW+1)'(total_c);
	assign mag_c        = sample_q[SB-1] ? (~sample_q + 1'b1) : sample_q;
	assign div_floor_c  = (peak_q < PEAK_FLOOR) ? PEAK_FLOOR : peak_q;
	assign over_c       = $unsigned(prod) > PW'({max_level, {FR{1'b0}}});
	assign grow_c       = (MW'(peak_q) < MW'(max_level)) && (gain_q < cpgn_pkg::GAIN_LIMIT);
	assign out_free_c   = !out_valid_q || result.ready;

	// round half up, then clip to the sample range
	assign rnd_c = prod + $signed(PW'(cpgn_pkg::GAIN_HALF));
	assign y_c   = rnd_c >>> FR;

	always_comb begin
		if (y_c > Y_HI) begin
			sat_c = Y_HI[SB-1:0];
		end else if (y_c < Y_LO) begin
			sat_c = Y_LO[SB-1:0];
		end else begin
			sat_c = y_c[SB-1:0];
		end
	end

	always_comb begin
		alu_ctl.start = 1'b0;
		alu_ctl.op    = cpgn_pkg::ALU_MUL;
		alu_ctl.steps = '0;
		alu_a         = '0;
		alu_b         = '0;
		alu_dvd       = '0;
		alu_dsr       = '0;
		rd_en         = 1'b0;
		rd_addr       = fill_q;
		wr_en         = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (item.cmd == cpgn_pkg::CMD_SAMPLE) begin
						rd_en = 1'b1;
					end else if (held_q) begin
						alu_ctl.start = 1'b1;
						alu_ctl.op    = cpgn_pkg::ALU_DIV;
						alu_ctl.steps = cpgn_pkg::STEP_W'(LW + 1);
						alu_dvd       = {sum_c, {PAD{1'b0}}};
						alu_dsr       = DSW'(len_c);
					end else begin
						rd_en   = 1'b1;
						rd_addr = drain_q[IW-1:0];
					end
				end
			end
			ST_SMUL, ST_DMUL: begin
				alu_ctl.start = 1'b1;
				alu_a         = MW'($signed(rd_data));
				alu_b         = gain_q;
				wr_en         = (state_q == ST_SMUL);
			end
			ST_GSTEP: begin
				alu_ctl.start = 1'b1;
				alu_a         = MW'(gain_q);
				alu_b         = cpgn_pkg::GAIN_STEP;
			end
			ST_GCHK: begin
				alu_ctl.start = 1'b1;
				alu_a         = MW'(peak_q);
				alu_b         = gain_q;
			end
			ST_GCMP: begin
				if (over_c) begin
					alu_ctl.start = 1'b1;
					alu_ctl.op    = cpgn_pkg::ALU_DIV;
					alu_ctl.steps = cpgn_pkg::STEP_W'(DVW);
					alu_dvd       = DVW'({max_level, {FR{1'b0}}});
					alu_dsr       = DSW'(div_floor_c);
				end
			end
			ST_DMOD: begin
				rd_en   = alu_sts.done;
				rd_addr = rem[IW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			held_q  <= 1'b0;
			drain_q <= '0;
			peak_q  <= '0;
			gain_q  <= cpgn_pkg::GAIN_ONE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (item.cmd == cpgn_pkg::CMD_SAMPLE) begin
							// samples arriving mid-drain are dropped
							if (drain_q == '0) begin
								state_q <= ST_SMUL;
							end
						end else if (total_c == '0) begin
							fill_q  <= '0;
							held_q  <= 1'b0;
							drain_q <= '0;
							peak_q  <= '0;
							gain_q  <= cpgn_pkg::GAIN_ONE;
						end else if (held_q) begin
							state_q <= ST_DMOD;
						end else begin
							state_q <= ST_DMUL;
						end
					end
				end
				ST_SMUL: begin
					if (mag_c > peak_q) begin
						peak_q <= mag_c;
					end
					state_q <= ST_SEMIT;
				end
				ST_SEMIT: begin
					if (!held_q || out_free_c) begin
						if (last_fill_c) begin
							state_q <= ST_GSTEP;
						end else begin
							fill_q  <= fill_q + 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_GSTEP: begin
					state_q <= ST_GSCALE;
				end
				ST_GSCALE: begin
					if (grow_c) begin
						gain_q <= y_c[GB-1:0];
					end
					state_q <= ST_GCHK;
				end
				ST_GCHK: begin
					state_q <= ST_GCMP;
				end
				ST_GCMP: begin
					state_q <= over_c ? ST_GDIV : ST_GFIN;
				end
				ST_GDIV: begin
					if (alu_sts.done) begin
						gain_q  <= alu_sts.quo_wide ? cpgn_pkg::GAIN_MAX : quo[GB-1:0];
						state_q <= ST_GFIN;
					end
				end
				ST_GFIN: begin
					peak_q  <= '0;
					held_q  <= 1'b1;
					fill_q  <= '0;
					state_q <= ST_IDLE;
				end
				ST_DMOD: begin
					if (alu_sts.done) begin
						state_q <= ST_DMUL;
					end
				end
				ST_DMUL: begin
					state_q <= ST_DEMIT;
				end
				ST_DEMIT: begin
					if (out_free_c) begin
						if (last_drain_c) begin
							fill_q  <= '0;
							held_q  <= 1'b0;
							drain_q <= '0;
							peak_q  <= '0;
							gain_q  <= cpgn_pkg::GAIN_ONE;
						end else begin
							drain_q <= drain_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= item.sample;
		end
	end

	assign load_c = out_free_c &&
		(((state_q == ST_SEMIT) && held_q) || (state_q == ST_DEMIT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_c) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_c) begin
			out_sample_q <= sat_c;
			out_done_q   <= (state_q == ST_DEMIT) && last_drain_c;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.scaled_sample = out_sample_q;
	assign result.drain_done    = out_done_q;

endmodule
